FILE: src/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition tree parser package
// Shared types, constants and the root size function of the tree parser.
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int MAX_LEAVES_DEF  = 1024;

   localparam int CFG_DIM_W   = 9;
   localparam int COORD_W     = 8;
   localparam int LEAF_IDX_W  = 10;
   localparam int CODE_W      = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CODE_W-1:0] CODE_LEAF    = 2'd0;
   localparam logic [CODE_W-1:0] CODE_SPLIT_W = 2'd1;

   localparam logic [1:0] REG_LUMA_HEIGHT = 2'd0;
   localparam logic [1:0] REG_LUMA_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IS_CHROMA   = 2'd2;

   localparam logic [CFG_DIM_W-1:0] LUMA_HEIGHT_RST = 9'd16;
   localparam logic [CFG_DIM_W-1:0] LUMA_WIDTH_RST  = 9'd16;
   localparam logic                 IS_CHROMA_RST   = 1'b0;

   typedef struct packed {
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] right;
   } rect_type;

   typedef struct packed {
      logic [LEAF_IDX_W-1:0] leaf_index;
      rect_type              rect;
      logic                  tree_done;
      logic                  overflow_error;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
      logic       push;
      rect_type   push_rect;
      logic       pop_load;
      rect_type   keep_rect;
      logic       in_tree;
   } step_ctl_type;

   // Root dimension after chroma halving, clamped into 1..256.
   function automatic logic [CFG_DIM_W-1:0] root_dim(input logic [CFG_DIM_W-1:0] v,
                                                      input logic chroma);
      logic [CFG_DIM_W-1:0] d;
      d = chroma ? (v >> 1) : v;
      if (d == '0) begin
         d = 9'd1;
      end else if (d > 9'd256) begin
         d = 9'd256;
      end
      return d;
   endfunction

endpackage

FILE: src/partition_tree_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition tree parser
// Decodes pre-order split codes of a binary partition tree into leaf
// rectangles, with a stack of pending rectangles and a register port.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake           Carries
//   req_      in          valid / stall       split_code
//   rsp_      out         valid / stall       leaf index, corners, done, error
//   csr_      in / out    psel/penable/pready luma_height, luma_width, is_chroma
//
// One item is taken per cycle while req_stall is low; a leaf or error result
// goes into the output register, or the skid entry while that one is held.
// The top rectangle is registered; a leaf reads the stack, a split writes it.
// An output register plus one skid entry decouple the sides; req_stall rises
// only while the skid entry is occupied. Reset clears the tree state and
// restores the register defaults; the first item after reset starts a tree.
// ----------------------------------------------------------------------------
module partition_tree_parser_top #(
   parameter int STACK_DEPTH = ptp_pkg::STACK_DEPTH_DEF,
   parameter int MAX_LEAVES  = ptp_pkg::MAX_LEAVES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptp_pkg::CODE_W-1:0]      req_split_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ptp_pkg::LEAF_IDX_W-1:0]  rsp_leaf_index,
   output logic [ptp_pkg::COORD_W-1:0]     rsp_top_row,
   output logic [ptp_pkg::COORD_W-1:0]     rsp_left_col,
   output logic [ptp_pkg::COORD_W-1:0]     rsp_bottom_row,
   output logic [ptp_pkg::COORD_W-1:0]     rsp_right_col,
   output logic                            rsp_tree_done,
   output logic                            rsp_overflow_error,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ptp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ptp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ptp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int LW = $clog2(MAX_LEAVES + 1);
   localparam int IW = $clog2(STACK_DEPTH);

   logic [ptp_pkg::CFG_DIM_W-1:0] luma_height_ff;
   logic [ptp_pkg::CFG_DIM_W-1:0] luma_width_ff;
   logic                          is_chroma_ff;
   logic                          csr_write;
   logic [1:0]                    csr_reg;

   logic [CW-1:0]                 count_ff;
   logic [LW-1:0]                 leaf_ff;
   logic                          in_tree_ff;
   ptp_pkg::rect_type             top_ff;
   ptp_pkg::rect_type             top_in;
   ptp_pkg::rect_type             stack_ff [STACK_DEPTH];

   ptp_pkg::step_ctl_type         ctl;
   logic [CW-1:0]                 pop_count;
   logic [CW-1:0]                 count_in;
   logic [LW-1:0]                 leaf_in;
   logic [CW-1:0]                 read_slot;

   ptp_pkg::result_type           rsp_ff;
   logic                          rsp_valid_ff;
   ptp_pkg::result_type           skid_ff;
   logic                          skid_valid_ff;

   logic                          accept;
   logic                          res_valid;
   logic                          out_take;
   logic                          out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_height_ff <= ptp_pkg::LUMA_HEIGHT_RST;
         luma_width_ff  <= ptp_pkg::LUMA_WIDTH_RST;
         is_chroma_ff   <= ptp_pkg::IS_CHROMA_RST;
      end else if (csr_write) begin
         unique case (csr_reg)
            ptp_pkg::REG_LUMA_HEIGHT: begin
               luma_height_ff <= csr_pwdata[ptp_pkg::CFG_DIM_W-1:0];
            end
            ptp_pkg::REG_LUMA_WIDTH: begin
               luma_width_ff <= csr_pwdata[ptp_pkg::CFG_DIM_W-1:0];
            end
            ptp_pkg::REG_IS_CHROMA: begin
               is_chroma_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         ptp_pkg::REG_LUMA_HEIGHT: csr_prdata = ptp_pkg::CSR_DATA_W'(luma_height_ff);
         ptp_pkg::REG_LUMA_WIDTH:  csr_prdata = ptp_pkg::CSR_DATA_W'(luma_width_ff);
         ptp_pkg::REG_IS_CHROMA:   csr_prdata = ptp_pkg::CSR_DATA_W'(is_chroma_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   ptp_step #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LEAVES  (MAX_LEAVES)
   ) u_step (
      .split_code  (req_split_code),
      .in_tree     (in_tree_ff),
      .count       (count_ff),
      .leaf_count  (leaf_ff),
      .top_rect    (top_ff),
      .luma_height (luma_height_ff),
      .luma_width  (luma_width_ff),
      .is_chroma   (is_chroma_ff),
      .ctl         (ctl),
      .pop_count   (pop_count),
      .count_in    (count_in),
      .leaf_in     (leaf_in)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign res_valid = accept & ctl.emit;
   assign read_slot = pop_count - CW'(1);
   assign top_in    = ctl.pop_load ? stack_ff[read_slot[IW-1:0]] : ctl.keep_rect;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         leaf_ff    <= '0;
         in_tree_ff <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         leaf_ff    <= leaf_in;
         in_tree_ff <= ctl.in_tree;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_ff <= top_in;
      end
      if (accept && ctl.push) begin
         stack_ff[pop_count[IW-1:0]] <= ctl.push_rect;
      end
   end

   assign out_take = rsp_valid_ff & ~rsp_stall;
   assign out_free = ~rsp_valid_ff | out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff && out_free) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else if (res_valid) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_free) begin
         rsp_ff <= skid_ff;
      end else if (res_valid) begin
         if (out_free) begin
            rsp_ff <= ctl.result;
         end else begin
            skid_ff <= ctl.result;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_leaf_index     = rsp_ff.leaf_index;
   assign rsp_top_row        = rsp_ff.rect.top;
   assign rsp_left_col       = rsp_ff.rect.left;
   assign rsp_bottom_row     = rsp_ff.rect.bottom;
   assign rsp_right_col      = rsp_ff.rect.right;
   assign rsp_tree_done      = rsp_ff.tree_done;
   assign rsp_overflow_error = rsp_ff.overflow_error;

endmodule

FILE: src/ptp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition tree parser step logic
// Applies one split code to the top rectangle and works out the next stack
// state and the result item.
// ----------------------------------------------------------------------------
module ptp_step #(
   parameter int STACK_DEPTH = ptp_pkg::STACK_DEPTH_DEF,
   parameter int MAX_LEAVES  = ptp_pkg::MAX_LEAVES_DEF,
   localparam int CW = $clog2(STACK_DEPTH + 1),
   localparam int LW = $clog2(MAX_LEAVES + 1)
) (
   input  logic [ptp_pkg::CODE_W-1:0]    split_code,
   input  logic                          in_tree,
   input  logic [CW-1:0]                 count,
   input  logic [LW-1:0]                 leaf_count,
   input  ptp_pkg::rect_type             top_rect,
   input  logic [ptp_pkg::CFG_DIM_W-1:0] luma_height,
   input  logic [ptp_pkg::CFG_DIM_W-1:0] luma_width,
   input  logic                          is_chroma,
   output ptp_pkg::step_ctl_type         ctl,
   output logic [CW-1:0]                 pop_count,
   output logic [CW-1:0]                 count_in,
   output logic [LW-1:0]                 leaf_in
);

   logic [ptp_pkg::CFG_DIM_W-1:0] root_h;
   logic [ptp_pkg::CFG_DIM_W-1:0] root_w;
   ptp_pkg::rect_type             root_rect;
   ptp_pkg::rect_type             cur;
   logic [CW-1:0]                 eff_count;
   logic [LW-1:0]                 leaf_cur;
   logic [CW:0]                   need;
   logic [ptp_pkg::CFG_DIM_W-1:0] span;
   logic [ptp_pkg::COORD_W-1:0]   half;

   always_comb begin
      root_h           = ptp_pkg::root_dim(luma_height, is_chroma);
      root_w           = ptp_pkg::root_dim(luma_width, is_chroma);
      root_rect.top    = '0;
      root_rect.left   = '0;
      root_rect.bottom = ptp_pkg::COORD_W'(root_h - 9'd1);
      root_rect.right  = ptp_pkg::COORD_W'(root_w - 9'd1);

      cur       = in_tree ? top_rect : root_rect;
      eff_count = in_tree ? count : CW'(1);
      leaf_cur  = in_tree ? leaf_count : '0;
      pop_count = eff_count - CW'(1);
      need      = {1'b0, pop_count} + (CW+1)'(2);

      if (split_code == ptp_pkg::CODE_SPLIT_W) begin
         span = {1'b0, cur.right} - {1'b0, cur.left} + 9'd1;
      end else begin
         span = {1'b0, cur.bottom} - {1'b0, cur.top} + 9'd1;
      end
      half = ptp_pkg::COORD_W'(span >> 1);

      ctl       = '0;
      count_in  = '0;
      leaf_in   = '0;

      if (split_code == ptp_pkg::CODE_LEAF) begin
         if (leaf_cur >= LW'(MAX_LEAVES)) begin
            ctl.emit                  = 1'b1;
            ctl.result.tree_done      = 1'b1;
            ctl.result.overflow_error = 1'b1;
         end else begin
            ctl.emit              = 1'b1;
            ctl.result.leaf_index = ptp_pkg::LEAF_IDX_W'(leaf_cur);
            ctl.result.rect       = cur;
            ctl.result.tree_done  = (pop_count == '0);
            ctl.in_tree           = (pop_count != '0);
            ctl.pop_load          = (pop_count != '0);
            count_in              = pop_count;
            leaf_in               = (pop_count == '0) ? '0 : leaf_cur + LW'(1);
         end
      end else if (need > (CW+1)'(STACK_DEPTH)) begin
         ctl.emit                  = 1'b1;
         ctl.result.tree_done      = 1'b1;
         ctl.result.overflow_error = 1'b1;
      end else begin
         ctl.push      = 1'b1;
         ctl.in_tree   = 1'b1;
         ctl.push_rect = cur;
         ctl.keep_rect = cur;
         if (split_code == ptp_pkg::CODE_SPLIT_W) begin
            ctl.push_rect.left  = cur.left + half;
            ctl.keep_rect.right = cur.right - half;
         end else begin
            ctl.push_rect.top    = cur.top + half;
            ctl.keep_rect.bottom = cur.bottom - half;
         end
         count_in = CW'(need);
         leaf_in  = leaf_cur;
      end
   end

endmodule

FILE: test/partition_tree_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition tree parser testbench
// Feeds split codes to the parser under random sender gaps and receiver
// stalls, across several block sizes, and checks every leaf and error item
// against a tree decoder kept inside the bench. Register writes are read back.
// ----------------------------------------------------------------------------
module partition_tree_parser_top_tb;

   localparam logic [ptp_pkg::CODE_W-1:0] CODE_SPLIT_H     = 2'd2;
   localparam logic [ptp_pkg::CODE_W-1:0] CODE_SPLIT_H_ALT = 2'd3;
   localparam int unsigned RANDOM_CODES  = 660;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   class partition_scoreboard;
      ptp_pkg::rect_type              rect_stack[ptp_pkg::STACK_DEPTH_DEF];
      int unsigned                    depth;
      int unsigned                    leaves;
      bit                             in_tree;
      logic [ptp_pkg::CFG_DIM_W-1:0]  luma_height;
      logic [ptp_pkg::CFG_DIM_W-1:0]  luma_width;
      logic                           is_chroma;
      ptp_pkg::result_type            pending_leaves[$];
      int unsigned                    errors;

      function new();
         depth       = 0;
         leaves      = 0;
         in_tree     = 0;
         luma_height = 9'd16;
         luma_width  = 9'd16;
         is_chroma   = 1'b0;
         errors      = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [ptp_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            ptp_pkg::REG_LUMA_HEIGHT: luma_height = value[ptp_pkg::CFG_DIM_W-1:0];
            ptp_pkg::REG_LUMA_WIDTH:  luma_width  = value[ptp_pkg::CFG_DIM_W-1:0];
            ptp_pkg::REG_IS_CHROMA:   is_chroma   = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned root_size(logic [ptp_pkg::CFG_DIM_W-1:0] v);
         int unsigned d;
         d = is_chroma ? int'(v) / 2 : int'(v);
         if (d == 0) begin
            d = 1;
         end else if (d > 256) begin
            d = 256;
         end
         return d;
      endfunction

      function void push_error();
         ptp_pkg::result_type res;
         res = '0;
         res.tree_done      = 1'b1;
         res.overflow_error = 1'b1;
         in_tree = 0;
         depth   = 0;
         leaves  = 0;
         pending_leaves.push_back(res);
      endfunction

      function void decode_code(logic [ptp_pkg::CODE_W-1:0] code);
         ptp_pkg::rect_type    cur;
         ptp_pkg::rect_type    first;
         ptp_pkg::rect_type    second;
         ptp_pkg::result_type  res;
         int unsigned          half;
         if (!in_tree || depth == 0 || depth > ptp_pkg::STACK_DEPTH_DEF) begin
            cur        = '0;
            cur.bottom = ptp_pkg::COORD_W'(root_size(luma_height) - 1);
            cur.right  = ptp_pkg::COORD_W'(root_size(luma_width) - 1);
            rect_stack[0] = cur;
            depth   = 1;
            leaves  = 0;
            in_tree = 1;
         end
         depth = depth - 1;
         cur = rect_stack[depth];
         if (code == ptp_pkg::CODE_LEAF) begin
            if (leaves >= ptp_pkg::MAX_LEAVES_DEF) begin
               push_error();
               return;
            end
            res = '0;
            res.leaf_index = ptp_pkg::LEAF_IDX_W'(leaves);
            res.rect       = cur;
            leaves = leaves + 1;
            if (depth == 0) begin
               res.tree_done = 1'b1;
               in_tree = 0;
               leaves  = 0;
            end
            pending_leaves.push_back(res);
            return;
         end
         if (depth + 2 > ptp_pkg::STACK_DEPTH_DEF) begin
            push_error();
            return;
         end
         first  = cur;
         second = cur;
         if (code == ptp_pkg::CODE_SPLIT_W) begin
            half = (int'(cur.right) - int'(cur.left) + 1) / 2;
            second.left = cur.left + ptp_pkg::COORD_W'(half);
            first.right = cur.right - ptp_pkg::COORD_W'(half);
         end else begin
            half = (int'(cur.bottom) - int'(cur.top) + 1) / 2;
            second.top   = cur.top + ptp_pkg::COORD_W'(half);
            first.bottom = cur.bottom - ptp_pkg::COORD_W'(half);
         end
         rect_stack[depth]     = second;
         rect_stack[depth + 1] = first;
         depth = depth + 2;
      endfunction

      task report_mismatch(string msg);
         errors = errors + 1;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
         end
      endtask

      task check_leaf(ptp_pkg::result_type got);
         ptp_pkg::result_type want;
         if (pending_leaves.size() == 0) begin
            report_mismatch($sformatf("item with no expectation, leaf_index %0d",
                                      got.leaf_index));
            return;
         end
         want = pending_leaves.pop_front();
         check_field("leaf_index", 32'(got.leaf_index), 32'(want.leaf_index));
         check_field("top_row", 32'(got.rect.top), 32'(want.rect.top));
         check_field("left_col", 32'(got.rect.left), 32'(want.rect.left));
         check_field("bottom_row", 32'(got.rect.bottom), 32'(want.rect.bottom));
         check_field("right_col", 32'(got.rect.right), 32'(want.rect.right));
         check_field("tree_done", 32'(got.tree_done), 32'(want.tree_done));
         check_field("overflow_error", 32'(got.overflow_error), 32'(want.overflow_error));
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ptp_pkg::CODE_W-1:0]      req_split_code = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ptp_pkg::LEAF_IDX_W-1:0]  rsp_leaf_index;
   logic [ptp_pkg::COORD_W-1:0]     rsp_top_row;
   logic [ptp_pkg::COORD_W-1:0]     rsp_left_col;
   logic [ptp_pkg::COORD_W-1:0]     rsp_bottom_row;
   logic [ptp_pkg::COORD_W-1:0]     rsp_right_col;
   logic                            rsp_tree_done;
   logic                            rsp_overflow_error;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ptp_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [ptp_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [ptp_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   partition_scoreboard leaf_sb = new();
   int unsigned         cycle_count = 0;
   int unsigned         codes_sent = 0;
   int unsigned         burst_left = 0;
   int unsigned         mode_left = 0;
   stall_mode_type      stall_mode = STALL_NONE;

   partition_tree_parser_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_split_code     (req_split_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_leaf_index     (rsp_leaf_index),
      .rsp_top_row        (rsp_top_row),
      .rsp_left_col       (rsp_left_col),
      .rsp_bottom_row     (rsp_bottom_row),
      .rsp_right_col      (rsp_right_col),
      .rsp_tree_done      (rsp_tree_done),
      .rsp_overflow_error (rsp_overflow_error),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(40, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
         default:     rsp_stall <= (cycle_count[3:0] < 4'd12);
      endcase
   end

   always @(posedge clock) begin
      ptp_pkg::result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.leaf_index     = rsp_leaf_index;
         got.rect.top       = rsp_top_row;
         got.rect.left      = rsp_left_col;
         got.rect.bottom    = rsp_bottom_row;
         got.rect.right     = rsp_right_col;
         got.tree_done      = rsp_tree_done;
         got.overflow_error = rsp_overflow_error;
         leaf_sb.check_leaf(got);
      end
   end

   task automatic push_code(input logic [ptp_pkg::CODE_W-1:0] code);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid      <= 1'b1;
      req_split_code <= code;
      do @(posedge clock); while (req_stall);
      leaf_sb.decode_code(code);
      codes_sent = codes_sent + 1;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (leaf_sb.pending_leaves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx,
                            input logic [ptp_pkg::CFG_DIM_W-1:0] value);
      logic [ptp_pkg::CSR_DATA_W-1:0] mask;
      logic [ptp_pkg::CSR_DATA_W-1:0] data;
      mask = (idx == ptp_pkg::REG_IS_CHROMA) ? 32'h1 : 32'h1FF;
      data = ptp_pkg::CSR_DATA_W'(value) & mask;
      if ($urandom_range(0, 1) == 1) begin
         data = data | ($urandom() & ~mask);
      end
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      leaf_sb.set_reg(idx, data);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (data & mask)) begin
         leaf_sb.report_mismatch($sformatf("register %0d read %0h expected %0h",
                                           idx, csr_prdata, data & mask));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(input logic [ptp_pkg::CFG_DIM_W-1:0] height,
                               input logic [ptp_pkg::CFG_DIM_W-1:0] width,
                               input logic chroma);
      settle();
      csr_write(ptp_pkg::REG_LUMA_HEIGHT, height);
      csr_write(ptp_pkg::REG_LUMA_WIDTH, width);
      csr_write(ptp_pkg::REG_IS_CHROMA, ptp_pkg::CFG_DIM_W'(chroma));
   endtask

   function automatic logic [ptp_pkg::CFG_DIM_W-1:0] random_dim();
      int unsigned pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd2;
         3:       return 9'd256;
         4:       return 9'd257;
         5:       return 9'd511;
         default: return ptp_pkg::CFG_DIM_W'($urandom_range(2, 256));
      endcase
   endfunction

   // A guarded tree never splits past the stack limit and always closes;
   // an unguarded one usually runs into the stack limit.
   task automatic send_tree(input int unsigned split_pct, input bit guarded);
      int unsigned open_rects;
      int unsigned steps;
      steps = 0;
      do begin
         open_rects = leaf_sb.in_tree ? leaf_sb.depth : 1;
         if ((!guarded || open_rects < ptp_pkg::STACK_DEPTH_DEF) && steps < 60 &&
             $urandom_range(0, 99) < split_pct) begin
            push_code(ptp_pkg::CODE_W'($urandom_range(1, 3)));
         end else begin
            push_code(ptp_pkg::CODE_LEAF);
         end
         steps = steps + 1;
      end while (leaf_sb.in_tree);
   endtask

   initial begin
      int unsigned start_count;
      int unsigned phase;
      int unsigned pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_code(ptp_pkg::CODE_LEAF);
      push_code(CODE_SPLIT_H_ALT);
      push_code(ptp_pkg::CODE_SPLIT_W);
      push_code(ptp_pkg::CODE_LEAF);
      push_code(ptp_pkg::CODE_LEAF);
      push_code(ptp_pkg::CODE_LEAF);
      push_code(CODE_SPLIT_H);
      push_code(ptp_pkg::CODE_LEAF);
      push_code(ptp_pkg::CODE_LEAF);
      for (int i = 0; i < ptp_pkg::STACK_DEPTH_DEF; i++) begin
         push_code(ptp_pkg::CODE_W'(i % 3 + 1));
      end

      phase = 0;
      start_count = codes_sent;
      while (codes_sent - start_count < RANDOM_CODES) begin
         case (phase)
            0:       apply_config(9'd256, 9'd256, 1'b0);
            1:       apply_config(9'd2, 9'd2, 1'b0);
            2:       apply_config(9'd0, 9'd511, 1'b1);
            3:       apply_config(9'd511, 9'd257, 1'b0);
            4:       apply_config(9'd1, 9'd3, 1'b1);
            5:       apply_config(9'd256, 9'd2, 1'b1);
            6:       apply_config(9'd3, 9'd256, 1'b0);
            default: apply_config(random_dim(), random_dim(), 1'($urandom_range(0, 1)));
         endcase
         phase = phase + 1;
         repeat ($urandom_range(6, 12)) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               send_tree(45, 1'b1);
            end else if (pick < 85) begin
               repeat ($urandom_range(1, 10)) begin
                  push_code(ptp_pkg::CODE_W'($urandom_range(0, 3)));
               end
            end else begin
               send_tree(80, 1'b0);
            end
         end
      end

      settle();
      if (leaf_sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
